// ===== design/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define SEFC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition that must never be seen on a rising clock edge outside reset.
`define SEFC_NEVER(label, expr, msg) \
	`SEFC_ASSERT(label, !(expr), msg)

`endif

// ===== design/sefc_pkg.sv =====
package sefc_pkg;

	localparam int SAMPLE_BITS = 24;
	localparam int OUT_BITS = 23;
	localparam int TDATA_IN_W = 48;
	localparam int TDATA_OUT_W = 48;
	localparam int TANH_DEPTH = 256;
	localparam int IDX_W = $clog2(TANH_DEPTH);
	localparam int POS_SH = 19 - IDX_W;
	localparam int TAB_W = 31;
	localparam int QUO_W = 26;
	localparam int FRAC_SH = 21;
	localparam int PRE_SH = QUO_W - FRAC_SH;
	localparam int CNT_W = $clog2(QUO_W + 1);
	localparam int ACC_W = 56;
	localparam int MA_W = 36;
	localparam int MB_W = 17;

	localparam logic [16:0] LOW_SPLIT_COEFF = 17'd930;
	localparam logic [16:0] HIGH_SPLIT_COEFF = 17'd8834;
	localparam logic [16:0] EQ_WET = 17'd32113;
	localparam logic [16:0] EQ_DRY = 17'd655;
	localparam logic [16:0] FLT_WET = 17'd32604;
	localparam logic [16:0] FLT_DRY = 17'd164;
	localparam logic [14:0] RES_LIMIT = 15'd31130;
	localparam logic [15:0] DRIVE_FLOOR = 16'd410;
	localparam logic [15:0] FDRIVE_FLOOR = 16'd2048;
	localparam logic signed [31:0] OUT_LIMIT = 32'sd3145728;

	localparam logic [1:0] MODE_OFF = 2'd0;
	localparam logic [1:0] MODE_NORMAL = 2'd1;
	localparam logic [1:0] MODE_LINEAR = 2'd2;
	localparam logic [1:0] MODE_SAT = 2'd3;
	localparam logic [1:0] TYPE_HP = 2'd1;
	localparam logic [1:0] TYPE_BP = 2'd2;

	localparam logic [2:0] REG_MODE = 3'd0;
	localparam logic [2:0] REG_LOW_GAIN = 3'd1;
	localparam logic [2:0] REG_MID_GAIN = 3'd2;
	localparam logic [2:0] REG_HIGH_GAIN = 3'd3;
	localparam logic [2:0] REG_COEFF = 3'd4;
	localparam logic [2:0] REG_RESONANCE = 3'd5;
	localparam logic [2:0] REG_EQ_DRIVE = 3'd6;
	localparam logic [2:0] REG_FLT_DRIVE = 3'd7;

	typedef struct packed {
		logic en;
		logic clr;
		logic signed [MA_W-1:0] a;
		logic signed [MB_W-1:0] b;
	} mac_op_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	typedef logic [TAB_W-1:0] tanh_tab_t [0:TANH_DEPTH];

	// Shift and subtract quotient, used only while the table is elaborated.
	function automatic longint unsigned cdiv(longint unsigned n, longint unsigned d);
		longint unsigned q, r;
		q = 0;
		r = 0;
		for (int b = 63; b >= 0; b--) begin
			r = {r[62:0], n[b]};
			if (r >= d) begin
				r = r - d;
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic logic [TAB_W-1:0] tanh_entry(int unsigned i);
		longint unsigned t, a, a2, a3, a5, th;
		t = longint'(i) << (32 - IDX_W);
		a = t >> 8;
		a2 = (a * a) >> 30;
		a3 = (a2 * a) >> 30;
		a5 = (a3 * a2) >> 30;
		th = a - cdiv(a3, 3) + cdiv(2 * a5, 15);
		for (int k = 0; k < 8; k++) begin
			th = cdiv(th << 31, (64'd1 << 30) + ((th * th) >> 30));
		end
		return th[TAB_W-1:0];
	endfunction

	function automatic tanh_tab_t build_tanh();
		tanh_tab_t tab;
		for (int unsigned i = 0; i <= TANH_DEPTH; i++) begin
			tab[i] = tanh_entry(i);
		end
		return tab;
	endfunction

	localparam tanh_tab_t TANH_TAB = build_tanh();

	function automatic logic signed [31:0] sat32(logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] hi, lo;
		hi = 56'sd2147483647;
		lo = -56'sd2147483648;
		if (v > hi) begin
			return 32'sh7fffffff;
		end else if (v < lo) begin
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

endpackage

// ===== design/sefc_mac.sv =====
module sefc_mac (
	input logic clk,
	input logic arst_n,
	input sefc_pkg::mac_op_t op,
	output logic signed [sefc_pkg::ACC_W-1:0] acc
);
	import sefc_pkg::*;

	logic signed [ACC_W-1:0] prod;
	logic signed [ACC_W-1:0] acc_q;

	assign prod = ACC_W'(op.a) * ACC_W'(op.b);
	assign acc = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (op.en) begin
			acc_q <= (op.clr ? '0 : acc_q) + prod;
		end
	end

endmodule

// ===== design/sefc_div.sv =====
module sefc_div (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [sefc_pkg::TAB_W-1:0] num,
	input logic [sefc_pkg::TAB_W-1:0] den,
	output sefc_pkg::div_stat_t stat,
	output logic [sefc_pkg::QUO_W-1:0] quo
);
	import sefc_pkg::*;

	logic [TAB_W-1:0] rem_q;
	logic [TAB_W-1:0] den_q;
	logic [QUO_W-1:0] sh_q;
	logic [QUO_W-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [TAB_W:0] trial;
	logic fits;

	assign trial = {rem_q, sh_q[QUO_W-1]};
	assign fits = trial >= {1'b0, den_q};
	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quo = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
			den_q <= '0;
			sh_q <= '0;
			quo_q <= '0;
			cnt_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				rem_q <= num >> PRE_SH;
				sh_q <= {num[PRE_SH-1:0], {FRAC_SH{1'b0}}};
				den_q <= den;
				quo_q <= '0;
				cnt_q <= CNT_W'(QUO_W);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q <= fits ? TAB_W'(trial - {1'b0, den_q}) : trial[TAB_W-1:0];
				quo_q <= {quo_q[QUO_W-2:0], fits};
				sh_q <= sh_q << 1;
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

// ===== design/stereo_eq_resonant_filter_chain.sv =====
// Channel  Signals                          Contents
// input    s_tvalid s_tready s_tdata[47:0]  one stereo sample pair
// output   m_tvalid m_tready m_tdata[47:0]  one processed stereo pair
// config   cfg_we cfg_index cfg_data[15:0]  register writes, no read-back
// Items use the shared multiplier unless both stages are off, and each saturation
// also runs the 26-step divider.
// The block accepts no new item until the current one has been handed to the output register.
// Reset is asynchronous, loads config defaults and clears all else, with no clearing pass.
// A stalled output holds its item while the block processes the next one.
`include "assert_macros.svh"

module stereo_eq_resonant_filter_chain (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input logic [sefc_pkg::TDATA_IN_W-1:0] s_tdata,   // left_in, right_in
	output logic m_tvalid,
	input logic m_tready,
	output logic [sefc_pkg::TDATA_OUT_W-1:0] m_tdata, // left_out, right_out, zero pad
	input logic cfg_we,
	input logic [2:0] cfg_index,
	input logic [15:0] cfg_data
);
	import sefc_pkg::*;

	localparam logic [4:0] ST_IDLE = 5'd0;
	localparam logic [4:0] ST_CH = 5'd1;
	localparam logic [4:0] ST_E1 = 5'd2;
	localparam logic [4:0] ST_E2 = 5'd3;
	localparam logic [4:0] ST_E3 = 5'd4;
	localparam logic [4:0] ST_E4 = 5'd5;
	localparam logic [4:0] ST_E5 = 5'd6;
	localparam logic [4:0] ST_E6 = 5'd7;
	localparam logic [4:0] ST_E7 = 5'd8;
	localparam logic [4:0] ST_E8 = 5'd9;
	localparam logic [4:0] ST_E9 = 5'd10;
	localparam logic [4:0] ST_FS = 5'd11;
	localparam logic [4:0] ST_F1 = 5'd12;
	localparam logic [4:0] ST_F2 = 5'd13;
	localparam logic [4:0] ST_F3 = 5'd14;
	localparam logic [4:0] ST_F4 = 5'd15;
	localparam logic [4:0] ST_F5 = 5'd16;
	localparam logic [4:0] ST_F6 = 5'd17;
	localparam logic [4:0] ST_F7 = 5'd18;
	localparam logic [4:0] ST_F8 = 5'd19;
	localparam logic [4:0] ST_F9 = 5'd20;
	localparam logic [4:0] ST_F10 = 5'd21;
	localparam logic [4:0] ST_S0 = 5'd22;
	localparam logic [4:0] ST_L0 = 5'd23;
	localparam logic [4:0] ST_L1 = 5'd24;
	localparam logic [4:0] ST_L2 = 5'd25;
	localparam logic [4:0] ST_DW = 5'd26;
	localparam logic [4:0] ST_OUT = 5'd27;
	localparam logic [4:0] ST_WO = 5'd28;

	localparam logic [1:0] RET_EQ = 2'd0;
	localparam logic [1:0] RET_FIN = 2'd1;
	localparam logic [1:0] RET_FOUT = 2'd2;

	logic [4:0] state_q;
	logic [5:0] mode_q;
	logic [15:0] low_gain_q, mid_gain_q, high_gain_q, eq_drive_q, flt_drive_q;
	logic [14:0] coeff_q, res_q;

	logic signed [31:0] low_q [2];
	logic signed [31:0] hs_q [2];
	logic signed [31:0] s1_q [2];
	logic signed [31:0] s2_q [2];

	logic ch_q;
	logic [SAMPLE_BITS-1:0] in_r_q;
	logic signed [31:0] v_q, in_q, t_q, sv_q;
	logic signed [33:0] fb_q;
	logic [15:0] sd_q;
	logic [1:0] ret_q;
	logic lk_norm_q, lk_sat_q;
	logic [IDX_W-1:0] idx_q;
	logic [15:0] frac_q;
	logic [TAB_W-1:0] num_q;
	logic [OUT_BITS-1:0] outl_q, outr_q;
	logic m_valid_q;
	logic [TDATA_OUT_W-1:0] m_data_q;

	mac_op_t mac_op;
	logic signed [ACC_W-1:0] acc;
	div_stat_t div_stat;
	logic [QUO_W-1:0] quo;
	logic div_start;
	logic [TAB_W-1:0] div_den;

	logic signed [31:0] cur_low, cur_hs, cur_s1, cur_s2;
	logic [1:0] eqm, fm, ftype;
	logic [14:0] r_eff;
	logic [15:0] eq_d, fin_d, fout_d;
	logic signed [33:0] y_sel;
	logic [47:0] mag;
	logic [IDX_W+15:0] pos;
	logic [IDX_W:0] idx1;
	logic [TAB_W-1:0] lk_res;
	logic signed [31:0] q_signed, sat_res;
	logic signed [31:0] clamp_v;
	logic signed [31:0] s_new;
	logic out_in_range;

	assign cur_low = low_q[ch_q];
	assign cur_hs = hs_q[ch_q];
	assign cur_s1 = s1_q[ch_q];
	assign cur_s2 = s2_q[ch_q];
	assign eqm = mode_q[1:0];
	assign fm = mode_q[3:2];
	assign ftype = mode_q[5:4];
	assign r_eff = (res_q > RES_LIMIT) ? RES_LIMIT : res_q;
	assign eq_d = (eq_drive_q < DRIVE_FLOOR) ? DRIVE_FLOOR : eq_drive_q;
	assign fin_d = (flt_drive_q < DRIVE_FLOOR) ? DRIVE_FLOOR : flt_drive_q;
	assign fout_d = (flt_drive_q < FDRIVE_FLOOR) ? FDRIVE_FLOOR : flt_drive_q;

	always_comb begin
		case (ftype)
			TYPE_HP: y_sel = 34'(in_q) - 34'(cur_s2);
			TYPE_BP: y_sel = 34'(cur_s1) - 34'(cur_s2);
			default: y_sel = 34'(cur_s2);
		endcase
	end

	assign mag = lk_norm_q ? {11'd0, sd_q, 21'd0} : acc[47:0];
	assign pos = (IDX_W+16)'(mag >> POS_SH);
	assign idx1 = {1'b0, idx_q} + 1'b1;
	assign lk_res = lk_sat_q ? TANH_TAB[TANH_DEPTH] :
		TAB_W'(TANH_TAB[idx_q] + acc[46:16]);
	assign div_den = (lk_res == '0) ? TAB_W'(1) : lk_res;
	assign div_start = (state_q == ST_L2) && lk_norm_q;
	assign q_signed = 32'($signed({1'b0, quo}));
	assign sat_res = sv_q[31] ? -q_signed : q_signed;
	assign clamp_v = (v_q > OUT_LIMIT) ? OUT_LIMIT : ((v_q < -OUT_LIMIT) ? -OUT_LIMIT : v_q);
	assign s_new = (state_q == ST_E2) ? sat32(ACC_W'(cur_low) + (acc >>> 15)) :
		(state_q == ST_E3) ? sat32(ACC_W'(cur_hs) + (acc >>> 15)) :
		(state_q == ST_F4) ? sat32(ACC_W'(cur_s1) + (acc >>> 15)) :
		sat32(ACC_W'(cur_s2) + (acc >>> 15));

	always_comb begin
		mac_op.en = 1'b1;
		mac_op.clr = 1'b1;
		mac_op.a = '0;
		mac_op.b = '0;
		case (state_q)
			ST_E1: begin
				mac_op.a = MA_W'(v_q) - MA_W'(cur_low);
				mac_op.b = $signed(LOW_SPLIT_COEFF);
			end
			ST_E2: begin
				mac_op.a = MA_W'(v_q) - MA_W'(cur_hs);
				mac_op.b = $signed(HIGH_SPLIT_COEFF);
			end
			ST_E3: begin
				mac_op.a = MA_W'(cur_low);
				mac_op.b = $signed({1'b0, low_gain_q});
			end
			ST_E4: begin
				mac_op.clr = 1'b0;
				mac_op.a = MA_W'(cur_hs) - MA_W'(cur_low);
				mac_op.b = $signed({1'b0, mid_gain_q});
			end
			ST_E5: begin
				mac_op.clr = 1'b0;
				mac_op.a = MA_W'(v_q) - MA_W'(cur_hs);
				mac_op.b = $signed({1'b0, high_gain_q});
			end
			ST_E7: begin
				mac_op.a = MA_W'(t_q);
				mac_op.b = $signed(EQ_WET);
			end
			ST_E8: begin
				mac_op.clr = 1'b0;
				mac_op.a = MA_W'(v_q);
				mac_op.b = $signed(EQ_DRY);
			end
			ST_F1: begin
				mac_op.a = MA_W'(cur_s1) - MA_W'(cur_s2);
				mac_op.b = $signed({2'b0, r_eff});
			end
			ST_F3: begin
				mac_op.a = MA_W'(in_q) - MA_W'(fb_q) - MA_W'(cur_s1);
				mac_op.b = $signed({2'b0, coeff_q});
			end
			ST_F5: begin
				mac_op.a = MA_W'(cur_s1) - MA_W'(cur_s2);
				mac_op.b = $signed({2'b0, coeff_q});
			end
			ST_F8: begin
				mac_op.a = MA_W'(t_q);
				mac_op.b = $signed(FLT_WET);
			end
			ST_F9: begin
				mac_op.clr = 1'b0;
				mac_op.a = MA_W'(in_q);
				mac_op.b = $signed(FLT_DRY);
			end
			ST_S0: begin
				mac_op.a = sv_q[31] ? -MA_W'(sv_q) : MA_W'(sv_q);
				mac_op.b = $signed({1'b0, sd_q});
			end
			ST_L1: begin
				mac_op.a = $signed({5'd0, TANH_TAB[idx1]}) - $signed({5'd0, TANH_TAB[idx_q]});
				mac_op.b = $signed({1'b0, frac_q});
			end
			default: begin
				mac_op.en = 1'b0;
			end
		endcase
	end

	sefc_mac u_mac (
		.clk(clk),
		.arst_n(arst_n),
		.op(mac_op),
		.acc(acc)
	);

	sefc_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.num(num_q),
		.den(div_den),
		.stat(div_stat),
		.quo(quo)
	);

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_valid_q;
	assign m_tdata = m_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mode_q <= 6'd5;
			low_gain_q <= 16'd4096;
			mid_gain_q <= 16'd4096;
			high_gain_q <= 16'd4096;
			coeff_q <= 15'd4021;
			res_q <= '0;
			eq_drive_q <= 16'd4096;
			flt_drive_q <= 16'd4096;
			for (int c = 0; c < 2; c++) begin
				low_q[c] <= '0;
				hs_q[c] <= '0;
				s1_q[c] <= '0;
				s2_q[c] <= '0;
			end
			ch_q <= 1'b0;
			in_r_q <= '0;
			v_q <= '0;
			in_q <= '0;
			t_q <= '0;
			sv_q <= '0;
			fb_q <= '0;
			sd_q <= '0;
			ret_q <= RET_EQ;
			lk_norm_q <= 1'b0;
			lk_sat_q <= 1'b0;
			idx_q <= '0;
			frac_q <= '0;
			num_q <= '0;
			outl_q <= '0;
			outr_q <= '0;
			m_valid_q <= 1'b0;
			m_data_q <= '0;
		end else begin
			if (m_tready && (state_q != ST_WO)) begin
				m_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_MODE: mode_q <= cfg_data[5:0];
					REG_LOW_GAIN: low_gain_q <= cfg_data;
					REG_MID_GAIN: mid_gain_q <= cfg_data;
					REG_HIGH_GAIN: high_gain_q <= cfg_data;
					REG_COEFF: coeff_q <= cfg_data[14:0];
					REG_RESONANCE: res_q <= cfg_data[14:0];
					REG_EQ_DRIVE: eq_drive_q <= cfg_data;
					REG_FLT_DRIVE: flt_drive_q <= cfg_data;
					default: ;
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						v_q <= 32'($signed(s_tdata[SAMPLE_BITS-1:0]));
						in_r_q <= s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
						ch_q <= 1'b0;
						state_q <= ST_CH;
					end
				end
				ST_CH: state_q <= (eqm == MODE_OFF) ? ST_FS : ST_E1;
				ST_E1: state_q <= ST_E2;
				ST_E2: begin
					low_q[ch_q] <= s_new;
					state_q <= ST_E3;
				end
				ST_E3: begin
					hs_q[ch_q] <= s_new;
					state_q <= ST_E4;
				end
				ST_E4: state_q <= ST_E5;
				ST_E5: state_q <= ST_E6;
				ST_E6: begin
					t_q <= sat32(acc >>> 12);
					case (eqm)
						MODE_NORMAL: state_q <= ST_E7;
						MODE_SAT: begin
							sv_q <= sat32(acc >>> 12);
							sd_q <= eq_d;
							ret_q <= RET_EQ;
							state_q <= ST_S0;
						end
						default: begin
							v_q <= sat32(acc >>> 12);
							state_q <= ST_FS;
						end
					endcase
				end
				ST_E7: state_q <= ST_E8;
				ST_E8: state_q <= ST_E9;
				ST_E9: begin
					v_q <= sat32(acc >>> 15);
					state_q <= ST_FS;
				end
				ST_FS: begin
					case (fm)
						MODE_OFF: state_q <= ST_OUT;
						MODE_SAT: begin
							sv_q <= v_q;
							sd_q <= fin_d;
							ret_q <= RET_FIN;
							state_q <= ST_S0;
						end
						default: begin
							in_q <= v_q;
							state_q <= ST_F1;
						end
					endcase
				end
				ST_F1: state_q <= ST_F2;
				ST_F2: begin
					fb_q <= 34'(acc >>> 15);
					state_q <= ST_F3;
				end
				ST_F3: state_q <= ST_F4;
				ST_F4: begin
					s1_q[ch_q] <= s_new;
					state_q <= ST_F5;
				end
				ST_F5: state_q <= ST_F6;
				ST_F6: begin
					s2_q[ch_q] <= s_new;
					state_q <= ST_F7;
				end
				ST_F7: begin
					t_q <= sat32(ACC_W'(y_sel));
					case (fm)
						MODE_NORMAL: state_q <= ST_F8;
						MODE_SAT: begin
							sv_q <= sat32(ACC_W'(y_sel));
							sd_q <= fout_d;
							ret_q <= RET_FOUT;
							state_q <= ST_S0;
						end
						default: begin
							v_q <= sat32(ACC_W'(y_sel));
							state_q <= ST_OUT;
						end
					endcase
				end
				ST_F8: state_q <= ST_F9;
				ST_F9: state_q <= ST_F10;
				ST_F10: begin
					v_q <= sat32(acc >>> 15);
					state_q <= ST_OUT;
				end
				ST_S0: begin
					lk_norm_q <= 1'b0;
					state_q <= ST_L0;
				end
				ST_L0: begin
					lk_sat_q <= (mag[47:35] != '0);
					idx_q <= pos[IDX_W+15:16];
					frac_q <= pos[15:0];
					state_q <= ST_L1;
				end
				ST_L1: state_q <= ST_L2;
				ST_L2: begin
					if (lk_norm_q) begin
						state_q <= ST_DW;
					end else begin
						num_q <= lk_res;
						lk_norm_q <= 1'b1;
						state_q <= ST_L0;
					end
				end
				ST_DW: begin
					if (div_stat.done) begin
						case (ret_q)
							RET_EQ: begin
								v_q <= sat_res;
								state_q <= ST_FS;
							end
							RET_FIN: begin
								in_q <= sat_res;
								state_q <= ST_F1;
							end
							RET_FOUT: begin
								v_q <= sat_res;
								state_q <= ST_OUT;
							end
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_OUT: begin
					if (!ch_q) begin
						outl_q <= clamp_v[OUT_BITS-1:0];
						v_q <= 32'($signed(in_r_q));
						ch_q <= 1'b1;
						state_q <= ST_CH;
					end else begin
						outr_q <= clamp_v[OUT_BITS-1:0];
						state_q <= ST_WO;
					end
				end
				ST_WO: begin
					if (!m_valid_q || m_tready) begin
						m_data_q <= {{(TDATA_OUT_W-2*OUT_BITS){1'b0}}, outr_q, outl_q};
						m_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_in_range = ($signed(m_tdata[45:23]) <= 23'sd3145728) &&
		($signed(m_tdata[45:23]) >= -23'sd3145728) &&
		($signed(m_tdata[22:0]) <= 23'sd3145728) &&
		($signed(m_tdata[22:0]) >= -23'sd3145728);

	`SEFC_NEVER(a_ready_div_idle, s_tready && div_stat.busy, "divider busy while taking an item")
	`SEFC_ASSERT(a_div_done_wait, div_stat.done |-> (state_q == ST_DW), "quotient arrived outside wait")
	`SEFC_ASSERT(a_out_range, m_tvalid |-> out_in_range, "output outside clamp range")

endmodule

// ===== tb/testbench.sv =====
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import sefc_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int PHASES = 19;
	localparam int PHASE_ITEMS = 100;
	localparam int DIR_ROWS = 20;
	localparam longint SMAX = 8388607;
	localparam longint SMIN = -8388608;

	typedef struct packed {
		logic [5:0] mode;
		logic signed [23:0] left;
		logic signed [23:0] right;
		logic known;
		logic signed [22:0] exp_left;
		logic signed [22:0] exp_right;
	} stim_row_t;

	typedef struct packed {
		logic signed [22:0] left;
		logic signed [22:0] right;
	} pair_out_t;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [TDATA_IN_W-1:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	logic [TDATA_OUT_W-1:0] m_tdata;
	logic cfg_we;
	logic [2:0] cfg_index;
	logic [15:0] cfg_data;

	pair_out_t expected_pairs[$];
	longint unsigned tanh_curve [0:TANH_DEPTH];

	logic [5:0] mode_reg;
	longint low_gain, mid_gain, high_gain, cut_coeff, res_amount, eq_drv, flt_drv;
	longint lp_low [2];
	longint lp_split [2];
	longint res_s1 [2];
	longint res_s2 [2];

	int mismatches = 0;
	int pairs_sent = 0;
	int pairs_checked = 0;
	int idle_cycles = 0;
	bit steady = 0;
	bit dir_known = 0;
	pair_out_t dir_expect;

	stim_row_t dir_rows [0:DIR_ROWS-1] = '{
		'{6'd5, 24'sd0, 24'sd0, 1'b1, 23'sd0, 23'sd0},
		'{6'd5, 24'sd8388607, -24'sd8388608, 1'b0, 23'sd0, 23'sd0},
		'{6'd5, -24'sd8388608, 24'sd8388607, 1'b0, 23'sd0, 23'sd0},
		'{6'd5, 24'sd1, -24'sd1, 1'b0, 23'sd0, 23'sd0},
		'{6'd5, 24'sd2097152, -24'sd2097152, 1'b0, 23'sd0, 23'sd0},
		'{6'd0, 24'sd8388607, -24'sd8388608, 1'b1, 23'sd3145728, -23'sd3145728},
		'{6'd0, 24'sd3145728, -24'sd3145729, 1'b1, 23'sd3145728, -23'sd3145728},
		'{6'd0, 24'sd5, -24'sd5, 1'b1, 23'sd5, -23'sd5},
		'{6'd15, 24'sd8388607, -24'sd8388608, 1'b0, 23'sd0, 23'sd0},
		'{6'd15, -24'sd8388608, 24'sd8388607, 1'b0, 23'sd0, 23'sd0},
		'{6'd15, 24'sd123456, -24'sd654321, 1'b0, 23'sd0, 23'sd0},
		'{6'd26, 24'sd8388607, 24'sd8388607, 1'b0, 23'sd0, 23'sd0},
		'{6'd26, -24'sd1000000, 24'sd0, 1'b0, 23'sd0, 23'sd0},
		'{6'd46, 24'sd8388607, -24'sd8388608, 1'b0, 23'sd0, 23'sd0},
		'{6'd46, 24'sd400000, -24'sd3000000, 1'b0, 23'sd0, 23'sd0},
		'{6'd53, 24'sd2000000, -24'sd2000000, 1'b0, 23'sd0, 23'sd0},
		'{6'd63, 24'sd8388607, -24'sd8388608, 1'b0, 23'sd0, 23'sd0},
		'{6'd63, -24'sd4194304, 24'sd4194304, 1'b0, 23'sd0, 23'sd0},
		'{6'd9, 24'sd1500000, -24'sd700000, 1'b0, 23'sd0, 23'sd0},
		'{6'd6, -24'sd8388608, 24'sd8388607, 1'b0, 23'sd0, 23'sd0}
	};

	stereo_eq_resonant_filter_chain u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic void build_curve();
		longint unsigned t, a, a2, a3, a5, th;
		for (int i = 0; i <= TANH_DEPTH; i++) begin
			t = (longint'(i) << 32) / TANH_DEPTH;
			a = t >> 8;
			a2 = (a * a) >> 30;
			a3 = (a2 * a) >> 30;
			a5 = (a3 * a2) >> 30;
			th = a - a3 / 3 + (2 * a5) / 15;
			for (int k = 0; k < 8; k++) begin
				th = (th << 31) / ((64'd1 << 30) + ((th * th) >> 30));
			end
			tanh_curve[i] = th;
		end
	endfunction

	function automatic longint clip32(longint v);
		if (v > 64'sd2147483647) begin
			return 64'sd2147483647;
		end else if (v < -64'sd2147483648) begin
			return -64'sd2147483648;
		end
		return v;
	endfunction

	function automatic longint unsigned curve_at(longint unsigned mag);
		longint unsigned pos, idx, frac, t0, t1;
		if (mag >= (64'd1 << 35)) begin
			return tanh_curve[TANH_DEPTH];
		end
		pos = (mag * TANH_DEPTH) >> 19;
		idx = pos >> 16;
		frac = pos & 64'hFFFF;
		if (idx >= TANH_DEPTH) begin
			return tanh_curve[TANH_DEPTH];
		end
		t0 = tanh_curve[idx];
		t1 = tanh_curve[idx + 1];
		return t0 + (((t1 - t0) * frac) >> 16);
	endfunction

	function automatic longint soft_clip(longint v, longint drv);
		longint unsigned d, mag, num, norm, q;
		d = (drv < DRIVE_FLOOR) ? DRIVE_FLOOR : drv;
		mag = longint'(v < 0 ? -v : v) * d;
		num = curve_at(mag);
		norm = curve_at(d << 21);
		if (norm == 0) begin
			norm = 1;
		end
		q = (num << 21) / norm;
		return v < 0 ? -longint'(q) : longint'(q);
	endfunction

	function automatic longint eq_bands(longint x, int ch);
		longint low, hs, y;
		if (mode_reg[1:0] == MODE_OFF) begin
			return x;
		end
		low = clip32(lp_low[ch] + ((longint'(LOW_SPLIT_COEFF) * (x - lp_low[ch])) >>> 15));
		hs = clip32(lp_split[ch] + ((longint'(HIGH_SPLIT_COEFF) * (x - lp_split[ch])) >>> 15));
		lp_low[ch] = low;
		lp_split[ch] = hs;
		y = low * low_gain + (hs - low) * mid_gain + (x - hs) * high_gain;
		y = clip32(y >>> 12);
		if (mode_reg[1:0] == MODE_NORMAL) begin
			y = (longint'(EQ_WET) * y + longint'(EQ_DRY) * x) >>> 15;
		end else if (mode_reg[1:0] == MODE_SAT) begin
			y = soft_clip(y, eq_drv);
		end
		return clip32(y);
	endfunction

	function automatic longint resonant_filter(longint x, int ch);
		longint drive_in, s1, s2, fb, y, r;
		if (mode_reg[3:2] == MODE_OFF) begin
			return x;
		end
		drive_in = (mode_reg[3:2] == MODE_SAT) ? soft_clip(x, flt_drv) : x;
		r = (res_amount > RES_LIMIT) ? longint'(RES_LIMIT) : res_amount;
		fb = (r * (res_s1[ch] - res_s2[ch])) >>> 15;
		s1 = clip32(res_s1[ch] + ((cut_coeff * (drive_in - fb - res_s1[ch])) >>> 15));
		s2 = clip32(res_s2[ch] + ((cut_coeff * (s1 - res_s2[ch])) >>> 15));
		res_s1[ch] = s1;
		res_s2[ch] = s2;
		if (mode_reg[5:4] == TYPE_HP) begin
			y = drive_in - s2;
		end else if (mode_reg[5:4] == TYPE_BP) begin
			y = s1 - s2;
		end else begin
			y = s2;
		end
		y = clip32(y);
		if (mode_reg[3:2] == MODE_NORMAL) begin
			y = (longint'(FLT_WET) * y + longint'(FLT_DRY) * drive_in) >>> 15;
		end else if (mode_reg[3:2] == MODE_SAT) begin
			y = soft_clip(y, (flt_drv < FDRIVE_FLOOR) ? longint'(FDRIVE_FLOOR) : flt_drv);
		end
		return clip32(y);
	endfunction

	function automatic logic signed [22:0] process_sample(logic signed [23:0] s, int ch);
		longint v;
		v = resonant_filter(eq_bands(longint'(s), ch), ch);
		if (v > OUT_LIMIT) begin
			v = OUT_LIMIT;
		end else if (v < -longint'(OUT_LIMIT)) begin
			v = -longint'(OUT_LIMIT);
		end
		return v[22:0];
	endfunction

	task automatic write_reg(logic [2:0] idx, logic [15:0] val);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			REG_MODE: mode_reg = val[5:0];
			REG_LOW_GAIN: low_gain = val;
			REG_MID_GAIN: mid_gain = val;
			REG_HIGH_GAIN: high_gain = val;
			REG_COEFF: cut_coeff = val[14:0];
			REG_RESONANCE: res_amount = val[14:0];
			REG_EQ_DRIVE: eq_drv = val;
			REG_FLT_DRIVE: flt_drv = val;
			default: ;
		endcase
	endtask

	task automatic drain();
		s_tvalid = 1'b0;
		while (expected_pairs.size() != 0) begin
			@(negedge clk);
		end
		repeat (4) @(negedge clk);
	endtask

	task automatic send_pair(logic signed [23:0] l, logic signed [23:0] r);
		pair_out_t p;
		while (!steady && $urandom_range(0, 99) < 25) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = {r, l};
		do begin
			@(posedge clk);
		end while (!s_tready);
		p.left = process_sample(l, 0);
		p.right = process_sample(r, 1);
		if (dir_known) begin
			p = dir_expect;
		end
		expected_pairs.push_back(p);
		pairs_sent++;
		@(negedge clk);
	endtask

	function automatic logic signed [23:0] pick_sample(logic signed [23:0] prev);
		case ($urandom_range(0, 9))
			0: return $urandom_range(0, 1) ? SMAX[23:0] : SMIN[23:0];
			1, 2, 3: return 24'($signed($urandom_range(0, 4194304)) - 2097152);
			4, 5: return prev + 24'($signed($urandom_range(0, 65536)) - 32768);
			default: return 24'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] pick_value(int unsigned hi);
		case ($urandom_range(0, 5))
			0: return 16'd0;
			1: return 16'(hi);
			2: return 16'($urandom_range(0, 8192));
			default: return 16'($urandom_range(0, hi));
		endcase
	endfunction

	always @(negedge clk) begin
		m_tready <= (steady || $urandom_range(0, 99) >= 25) ? 1'b1 : 1'b0;
	end

	always @(posedge clk) begin
		pair_out_t want, got;
		if (arst_n) begin
			if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
				if (idle_cycles >= WATCHDOG_LIMIT) begin
					$display("Testbench completed WITH ERRORS");
					$finish;
				end
			end
			if (m_tvalid && m_tready) begin
				got.left = m_tdata[22:0];
				got.right = m_tdata[45:23];
				if (expected_pairs.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("Unexpected output item %h", m_tdata);
					end
				end else begin
					want = expected_pairs.pop_front();
					pairs_checked++;
					if (got != want) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("Mismatch on item %0d: left %0d expected %0d, right %0d expected %0d",
								pairs_checked, got.left, want.left, got.right, want.right);
						end
					end
				end
			end
		end
	end

	initial begin
		logic signed [23:0] prev_l, prev_r;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_we = 1'b0;
		cfg_index = REG_MODE;
		cfg_data = '0;
		build_curve();
		mode_reg = 6'd5;
		low_gain = 4096;
		mid_gain = 4096;
		high_gain = 4096;
		cut_coeff = 4021;
		res_amount = 0;
		eq_drv = 4096;
		flt_drv = 4096;
		for (int c = 0; c < 2; c++) begin
			lp_low[c] = 0;
			lp_split[c] = 0;
			res_s1[c] = 0;
			res_s2[c] = 0;
		end
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int i = 0; i < DIR_ROWS; i++) begin
			if (dir_rows[i].mode != mode_reg) begin
				drain();
				write_reg(REG_MODE, 16'(dir_rows[i].mode));
			end
			dir_known = dir_rows[i].known;
			dir_expect.left = dir_rows[i].exp_left;
			dir_expect.right = dir_rows[i].exp_right;
			send_pair(dir_rows[i].left, dir_rows[i].right);
		end
		dir_known = 1'b0;

		prev_l = '0;
		prev_r = '0;
		for (int ph = 0; ph < PHASES; ph++) begin
			drain();
			if (ph == 0) begin
				write_reg(REG_MODE, 16'd63);
				write_reg(REG_LOW_GAIN, 16'hFFFF);
				write_reg(REG_MID_GAIN, 16'hFFFF);
				write_reg(REG_HIGH_GAIN, 16'hFFFF);
				write_reg(REG_COEFF, 16'd32767);
				write_reg(REG_RESONANCE, 16'd32767);
				write_reg(REG_EQ_DRIVE, 16'hFFFF);
				write_reg(REG_FLT_DRIVE, 16'hFFFF);
			end else if (ph == 1) begin
				write_reg(REG_MODE, 16'd15);
				write_reg(REG_LOW_GAIN, 16'd0);
				write_reg(REG_MID_GAIN, 16'd0);
				write_reg(REG_HIGH_GAIN, 16'd0);
				write_reg(REG_COEFF, 16'd0);
				write_reg(REG_RESONANCE, 16'd0);
				write_reg(REG_EQ_DRIVE, 16'd0);
				write_reg(REG_FLT_DRIVE, 16'd0);
			end else if (ph == 2) begin
				write_reg(REG_MODE, 16'd47);
				write_reg(REG_LOW_GAIN, 16'd4096);
				write_reg(REG_MID_GAIN, 16'd8192);
				write_reg(REG_HIGH_GAIN, 16'd2048);
				write_reg(REG_COEFF, 16'd12000);
				write_reg(REG_RESONANCE, 16'd31500);
				write_reg(REG_EQ_DRIVE, 16'd300);
				write_reg(REG_FLT_DRIVE, 16'd1500);
			end else begin
				write_reg(REG_MODE, 16'($urandom_range(0, 63)));
				write_reg(REG_LOW_GAIN, pick_value(65535));
				write_reg(REG_MID_GAIN, pick_value(65535));
				write_reg(REG_HIGH_GAIN, pick_value(65535));
				write_reg(REG_COEFF, pick_value(32767));
				write_reg(REG_RESONANCE, pick_value(32767));
				write_reg(REG_EQ_DRIVE, pick_value(65535));
				write_reg(REG_FLT_DRIVE, pick_value(65535));
			end
			steady = (ph == 9);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				prev_l = pick_sample(prev_l);
				prev_r = pick_sample(prev_r);
				send_pair(prev_l, prev_r);
			end
			steady = 1'b0;
		end
		s_tvalid = 1'b0;

		while (expected_pairs.size() != 0) begin
			@(negedge clk);
		end
		repeat (300) @(negedge clk);
		$display("Sent %0d stereo items through %0d register settings, checked %0d outputs.",
			pairs_sent, PHASES + 9, pairs_checked);
		$display("Settings covered every mode, filter type, gain, drive and resonance extreme.");
		if (mismatches == 0 && expected_pairs.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
